// File: hdl/bpq_pkg.sv
// Shared types and constants of the beep pattern queue.
`timescale 1ns / 1ps

package bpq_pkg;

    // Pattern ring depth and index width
    localparam int QUEUE_DEPTH = 8;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Request queue between front and back (power of two depth)
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    // Field widths
    localparam int TOTAL_W     = 16;
    localparam int PHASE_W     = 8;
    localparam int SUM_W       = PHASE_W + 2;
    localparam int DIV_CNT_W   = $clog2(TOTAL_W);

    localparam logic KIND_ENQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_REJECT,
        CMD_TICK
    } cmd_op_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [PHASE_W-1:0] on1;
        logic [PHASE_W-1:0] off1;
        logic [PHASE_W-1:0] on2;
        logic [PHASE_W-1:0] off2;
    } pattern_t;

    typedef struct packed {
        cmd_op_t  op;
        pattern_t pat;
    } cmd_t;

    typedef struct packed {
        logic buzzer_on;
        logic accepted;
        logic queue_full;
        logic queue_empty;
    } res_t;

endpackage

// File: hdl/bpq_front.sv
// Front end: classifies incoming requests and buffers them for the back end.
`timescale 1ns / 1ps

module bpq_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         kind,
    input  logic [bpq_pkg::TOTAL_W-1:0]  total_time,
    input  logic [bpq_pkg::PHASE_W-1:0]  first_on,
    input  logic [bpq_pkg::PHASE_W-1:0]  first_off,
    input  logic [bpq_pkg::PHASE_W-1:0]  second_on,
    input  logic [bpq_pkg::PHASE_W-1:0]  second_off,
    output logic                         cmd_valid,
    output bpq_pkg::cmd_t                cmd,
    input  logic                         cmd_pop
);
    import bpq_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] cnt_reg, cnt_next;
    cmd_t                 cmd_in;
    logic                 wr_en;
    logic                 rd_en;

    // Zero-total enqueues are rejected here; full-queue rejects are the back end's call
    always_comb
    begin
        cmd_in.pat.total = total_time;
        cmd_in.pat.on1   = first_on;
        cmd_in.pat.off1  = first_off;
        cmd_in.pat.on2   = second_on;
        cmd_in.pat.off2  = second_off;
        if (kind == KIND_TICK)
            cmd_in.op = CMD_TICK;
        else if (total_time == '0)
            cmd_in.op = CMD_REJECT;
        else
            cmd_in.op = CMD_ENQ;
    end

    assign full      = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign wr_en     = push && !full;
    assign rd_en     = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: hdl/bpq_mod_unit.sv
// Bit-serial restoring modulo unit: tick count modulo phase sum.
`timescale 1ns / 1ps

module bpq_mod_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bpq_pkg::TOTAL_W-1:0]  dividend,
    input  logic [bpq_pkg::SUM_W-1:0]    divisor,
    output logic                         done,
    output logic [bpq_pkg::SUM_W-1:0]    remainder
);
    import bpq_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TOTAL_W-1:0]   dvd_reg;
    logic [SUM_W-1:0]     dsr_reg;
    logic [SUM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W:0]       trial;
    logic [SUM_W:0]       diff;

    // Partial remainder stays below 2*divisor, so one extra bit covers the trial
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[TOTAL_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = (trial >= {1'b0, dsr_reg}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(TOTAL_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[TOTAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("modulo unit did not go busy after start");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("modulo done without a finished run");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dsr_reg)
        else $error("partial remainder out of range");

endmodule

// File: hdl/bpq_back.sv
// Back end: pattern ring, playback sequencer and result register.
`timescale 1ns / 1ps

module bpq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  bpq_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    output logic           empty,
    input  logic           pop,
    output bpq_pkg::res_t  res
);
    import bpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_DIV,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [PTR_W-1:0]     tail_reg, tail_next;
    logic                 not_full_reg, not_full_next;
    logic [TOTAL_W-1:0]   count_reg, count_next;
    logic                 level_reg, level_next;
    logic                 sum_zero_reg, sum_zero_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_reg, res_next;

    pattern_t             store [QUEUE_DEPTH];
    pattern_t             pat_reg;
    logic                 store_wr;

    logic                 q_empty;
    logic [SUM_W-1:0]     sum;
    logic                 div_start;
    logic                 div_done;
    logic [SUM_W-1:0]     div_rem;
    logic [PHASE_W:0]     half1;
    logic [SUM_W-1:0]     half2;
    logic                 phase_on;
    logic [TOTAL_W:0]     count_inc;
    logic                 accepted;
    logic                 emit;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] i);
        return (i == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign q_empty = (head_reg == tail_reg) && not_full_reg;

    // Phase sum of the head pattern, registered read of the ring
    assign sum = SUM_W'(pat_reg.on1) + SUM_W'(pat_reg.off1)
               + SUM_W'(pat_reg.on2) + SUM_W'(pat_reg.off2);
    assign div_start = (state_reg == S_SUM) && (sum != '0);

    bpq_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (count_reg),
        .divisor   (sum),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Phase lookup on the remainder
    always_comb
    begin
        half1 = {1'b0, pat_reg.on1} + {1'b0, pat_reg.off1};
        half2 = SUM_W'(half1) + SUM_W'(pat_reg.on2);
        if (div_rem < SUM_W'(half1))
            phase_on = div_rem < SUM_W'(pat_reg.on1);
        else
            phase_on = div_rem < half2;
        count_inc = {1'b0, count_reg} + 1'b1;
    end

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        not_full_next = not_full_reg;
        count_next    = count_reg;
        level_next    = level_reg;
        sum_zero_next = sum_zero_reg;
        res_valid_next = res_valid_reg && !pop;
        cmd_pop       = 1'b0;
        store_wr      = 1'b0;
        accepted      = 1'b0;
        emit          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Take a request only when the result slot is free
                if (cmd_valid && !res_valid_reg)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op)
                        CMD_ENQ:
                        begin
                            emit = 1'b1;
                            if (not_full_reg)
                            begin
                                store_wr      = 1'b1;
                                accepted      = 1'b1;
                                tail_next     = ring_next(tail_reg);
                                not_full_next = ring_next(tail_reg) != head_reg;
                            end
                        end
                        CMD_REJECT:
                            emit = 1'b1;
                        CMD_TICK:
                        begin
                            if (q_empty)
                                emit = 1'b1;
                            else
                                state_next = S_SUM;
                        end
                        default:
                            emit = 1'b1;
                    endcase
                end
            end
            S_SUM:
            begin
                sum_zero_next = (sum == '0);
                state_next    = (sum == '0) ? S_DONE : S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                emit       = 1'b1;
                state_next = S_IDLE;
                level_next = sum_zero_reg ? 1'b0 : phase_on;
                // Pattern ends when the advanced count reaches its total
                if (count_inc >= {1'b0, pat_reg.total})
                begin
                    level_next    = 1'b0;
                    head_next     = ring_next(head_reg);
                    count_next    = '0;
                    not_full_next = 1'b1;
                end
                else
                    count_next = count_inc[TOTAL_W-1:0];
            end
            default:
                state_next = S_IDLE;
        endcase

        res_next = res_reg;
        if (emit)
        begin
            res_valid_next       = 1'b1;
            res_next.buzzer_on   = level_next;
            res_next.accepted    = accepted;
            res_next.queue_full  = !not_full_next;
            res_next.queue_empty = (head_next == tail_next) && not_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_wr)
            store[tail_reg] <= cmd.pat;
        pat_reg <= store[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            not_full_reg  <= 1'b1;
            count_reg     <= '0;
            level_reg     <= 1'b0;
            sum_zero_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            not_full_reg  <= not_full_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            sum_zero_reg  <= sum_zero_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    assign empty = !res_valid_reg;
    assign res   = res_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !not_full_reg |-> head_reg == tail_reg)
        else $error("full flag set with head and tail apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> count_reg == '0)
        else $error("tick count nonzero with no pattern playing");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !res_valid_reg && state_reg == S_IDLE)
        else $error("request taken while a result is pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.accepted |-> !res_reg.queue_empty)
        else $error("accepted enqueue reported an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("modulo result outside of the divide state");

endmodule

// File: hdl/beep_pattern_queue_unit.sv
// Top level of the beep pattern queue: front end, request queue, playback back end.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  request  | push / full            | kind, total_time, first_on, first_off,
//           |                        | second_on, second_off
//  result   | empty / pop            | buzzer_on, accepted, queue_full, queue_empty
//
// Enqueue and reject results are registered as the back end takes the request.
// A tick on a playing pattern runs S_SUM, S_DIV, S_DONE; S_DIV waits on the 16-step
// bit-serial modulo unit, and a zero phase sum skips S_DIV.
// Reset is asynchronous active low and clears all control state; no clearing pass.
// A 4-entry request queue lets requests come in while the back end is busy or a
// result waits; the back end takes the next request only once the result is popped.
`timescale 1ns / 1ps

module beep_pattern_queue_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         kind,
    input  logic [bpq_pkg::TOTAL_W-1:0]  total_time,
    input  logic [bpq_pkg::PHASE_W-1:0]  first_on,
    input  logic [bpq_pkg::PHASE_W-1:0]  first_off,
    input  logic [bpq_pkg::PHASE_W-1:0]  second_on,
    input  logic [bpq_pkg::PHASE_W-1:0]  second_off,
    output logic                         empty,
    input  logic                         pop,
    output logic                         buzzer_on,
    output logic                         accepted,
    output logic                         queue_full,
    output logic                         queue_empty
);
    import bpq_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    logic cmd_pop;
    res_t res;

    bpq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .kind       (kind),
        .total_time (total_time),
        .first_on   (first_on),
        .first_off  (first_off),
        .second_on  (second_on),
        .second_off (second_off),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    bpq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign buzzer_on   = res.buzzer_on;
    assign accepted    = res.accepted;
    assign queue_full  = res.queue_full;
    assign queue_empty = res.queue_empty;

endmodule
